### hw/rtl/sehcd_pkg.sv
package sehcd_pkg;

  // Size of the receive buffer; one entry short of it holds payload.
  localparam int BUFFER_BYTES = 52;
  localparam int CAPACITY     = BUFFER_BYTES - 1;

  // Payload length and counter width, fixed by the payload_length port.
  localparam int LEN_W  = 6;
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [LEN_W-1:0] CAP_LEN      = LEN_W'(CAPACITY);
  localparam logic [LEN_W-1:0] CAP_LAST_LEN = LEN_W'(CAPACITY - 1);

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] CR_BYTE  = 8'h0d;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic seed;       // start of frame: seed sum, clear position and overflow
    logic add;        // add the received word to the running sum
    logic store;      // write the received word to the buffer
    logic etx_len;    // take the write position as the stored length
    logic set_ovf;    // flag a dropped payload word
    logic hex_hi;     // decode the high checksum character
    logic hex_lo;     // decode the low checksum character
    logic start_emit; // latch the terminator check and rewind the read counter
    logic read;       // issue a buffer read at the read counter
    logic advance;    // step the read counter
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_stx;
    logic is_etx;
    logic wp_last;    // the next stored word fills the buffer
    logic emit_last;  // the current read is the final result of the run
  } sts_t;

  // Returns {bad, nibble} for one ASCII hex character, either case.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

endpackage

### hw/rtl/sehcd_ram.sv
module sehcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/sehcd_dp.sv
module sehcd_dp
  import sehcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       rx_byte,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic [7:0]       payload_byte,
  output logic             payload_valid,
  output logic             last,
  output logic [LEN_W-1:0] payload_length,
  output logic [7:0]       computed_sum,
  output logic [7:0]       received_sum,
  output logic             sum_ok,
  output logic             overflowed,
  output logic             terminator_ok
);

  logic [7:0]       sum;
  logic [LEN_W-1:0] wp;
  logic [LEN_W-1:0] slen;
  logic [7:0]       rsum;
  logic             ovf;
  logic             term;
  logic [LEN_W-1:0] rd_cnt;
  logic [LEN_W-1:0] rd_last;
  logic [4:0]       hex;
  logic [7:0]       rdata;

  assign hex = hex_decode(rx_byte);

  // An empty frame still gives one result, so the run ends at index zero.
  assign rd_last = (slen == '0) ? '0 : slen - LEN_W'(1);

  assign sts.is_stx    = (rx_byte == STX_BYTE);
  assign sts.is_etx    = (rx_byte == ETX_BYTE);
  assign sts.wp_last   = (wp == CAP_LAST_LEN);
  assign sts.emit_last = (rd_cnt == rd_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      wp     <= '0;
      slen   <= '0;
      rsum   <= '0;
      ovf    <= 1'b0;
      term   <= 1'b0;
      rd_cnt <= '0;
    end else begin
      if (cmd.seed) begin
        sum <= STX_BYTE;
        wp  <= '0;
        ovf <= 1'b0;
      end
      if (cmd.add) begin
        sum <= sum + rx_byte;
      end
      if (cmd.store) begin
        wp <= wp + LEN_W'(1);
        if (wp == CAP_LAST_LEN) begin
          slen <= CAP_LEN;
        end
      end
      if (cmd.etx_len) begin
        slen <= wp;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.hex_hi) begin
        rsum <= hex[4] ? 8'hF0 : {hex[3:0], 4'h0};
      end
      if (cmd.hex_lo) begin
        rsum <= hex[4] ? 8'hFF : {rsum[7:4], hex[3:0]};
      end
      if (cmd.start_emit) begin
        term   <= (rx_byte == CR_BYTE);
        rd_cnt <= '0;
      end
      if (cmd.advance) begin
        rd_cnt <= rd_cnt + LEN_W'(1);
      end
    end
  end

  sehcd_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY)
  ) u_buf (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(wp[ADDR_W-1:0]),
    .wdata(rx_byte),
    .re   (cmd.read),
    .raddr(rd_cnt[ADDR_W-1:0]),
    .rdata(rdata)
  );

  assign payload_valid  = (slen != '0);
  assign payload_byte   = payload_valid ? rdata : 8'h00;
  assign last           = sts.emit_last;
  assign payload_length = slen;
  assign computed_sum   = sum;
  assign received_sum   = rsum;
  assign sum_ok         = (sum == rsum);
  assign overflowed     = ovf;
  assign terminator_ok  = term;

endmodule

### hw/rtl/sehcd_ctrl.sv
module sehcd_ctrl
  import sehcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_WAIT,
    S_DATA,
    S_DROP,
    S_HI,
    S_LO,
    S_END,
    S_READ,
    S_SHOW
  } state_t;

  state_t state;
  state_t state_next;
  logic   acc;

  assign in_ready  = (state != S_READ) && (state != S_SHOW);
  assign out_valid = (state == S_SHOW);
  assign acc       = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (acc && sts.is_stx) begin
      // A start byte restarts the frame from any receive state.
      cmd.seed   = 1'b1;
      state_next = S_DATA;
    end else begin
      case (state)
        S_WAIT: begin
          state_next = S_WAIT;
        end
        S_DATA: begin
          if (acc) begin
            cmd.add = 1'b1;
            if (sts.is_etx) begin
              cmd.etx_len = 1'b1;
              state_next  = S_HI;
            end else begin
              cmd.store = 1'b1;
              if (sts.wp_last) begin
                state_next = S_DROP;
              end
            end
          end
        end
        S_DROP: begin
          if (acc) begin
            cmd.add = 1'b1;
            if (sts.is_etx) begin
              state_next = S_HI;
            end else begin
              cmd.set_ovf = 1'b1;
            end
          end
        end
        S_HI: begin
          if (acc) begin
            cmd.hex_hi = 1'b1;
            state_next = S_LO;
          end
        end
        S_LO: begin
          if (acc) begin
            cmd.hex_lo = 1'b1;
            state_next = S_END;
          end
        end
        S_END: begin
          if (acc) begin
            cmd.start_emit = 1'b1;
            state_next     = S_READ;
          end
        end
        S_READ: begin
          cmd.read   = 1'b1;
          state_next = S_SHOW;
        end
        S_SHOW: begin
          if (out_ready) begin
            if (sts.emit_last) begin
              state_next = S_WAIT;
            end else begin
              cmd.advance = 1'b1;
              state_next  = S_READ;
            end
          end
        end
        default: begin
          state_next = S_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WAIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/stx_etx_hex_checksum_deframer_core.sv
// Receives a byte stream framed as STX, payload, ETX, two ASCII hex checksum
// characters and one final byte, and on that final byte delivers the stored
// payload as a run of words, each carrying the frame status (lengths, sums,
// overflow and terminator check); an empty frame gives one word with
// payload_valid low. While receiving, one input word is taken every cycle.
// Once the final byte is taken the input stalls for the readout: each result
// word needs a registered read of the payload buffer and then a state that
// presents the word, so a frame of L stored bytes holds the input for
// max(L,1) result words plus any output back-pressure. The buffer keeps up
// to 51 payload bytes; later payload bytes are summed but dropped and set
// overflowed. It needs no clearing after reset.
module stx_etx_hex_checksum_deframer_core
  import sehcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       payload_byte,
  output logic             payload_valid,
  output logic             last,
  output logic [LEN_W-1:0] payload_length,
  output logic [7:0]       computed_sum,
  output logic [7:0]       received_sum,
  output logic             sum_ok,
  output logic             overflowed,
  output logic             terminator_ok
);

  cmd_t cmd;
  sts_t sts;

  sehcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sehcd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .sts           (sts),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .last          (last),
    .payload_length(payload_length),
    .computed_sum  (computed_sum),
    .received_sum  (received_sum),
    .sum_ok        (sum_ok),
    .overflowed    (overflowed),
    .terminator_ok (terminator_ok)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken during readout");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (payload_length <= CAP_LEN))
    else $error("stored length beyond buffer capacity");

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !payload_valid) |-> (last && payload_byte == 8'h00))
    else $error("empty frame must give one word");

  a_back_to_rx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (in_ready && !out_valid))
    else $error("receiver not resumed after final word");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sehcd_pkg::*;

  localparam int LIMIT     = 200000;
  localparam int HOLD_OFF  = 300;
  localparam int ITEMS     = 220;

  typedef struct packed {
    logic [7:0]       data;
    logic             data_valid;
    logic             run_last;
    logic [LEN_W-1:0] length;
    logic [7:0]       calc_sum;
    logic [7:0]       rx_sum;
    logic             sum_match;
    logic             dropped;
    logic             cr_seen;
  } frame_word_t;

  typedef struct packed {
    logic [7:0]  code;
    logic        typed;
    frame_word_t want;
  } stim_row_t;

  typedef enum logic [2:0] {
    AWAIT_STX, IN_PAYLOAD, IN_DROP, CK_HIGH, CK_LOW, AWAIT_END
  } rx_phase_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       rx_byte;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       payload_byte;
  logic             payload_valid;
  logic             last;
  logic [LEN_W-1:0] payload_length;
  logic [7:0]       computed_sum;
  logic [7:0]       received_sum;
  logic             sum_ok;
  logic             overflowed;
  logic             terminator_ok;

  // Shadow of the deframer state.
  rx_phase_t   rx_phase;
  logic [7:0]  shadow_buf [CAPACITY];
  int unsigned wr_pos;
  int unsigned kept_len;
  logic [7:0]  sum_acc;
  logic [7:0]  ck_acc;
  logic        ovf_seen;

  frame_word_t expected_words [$];
  int unsigned error_count;
  int unsigned words_taken;
  int unsigned cycle_count;
  int unsigned sent_count;
  bit          steady;
  bit          hold_done;

  // Typed words are empty frames whose sums can be read off directly.
  stim_row_t directed_rows [27] = '{
    '{8'hFF,    1'b0, '0},
    '{STX_BYTE, 1'b0, '0},
    '{ETX_BYTE, 1'b0, '0},
    '{8'h30,    1'b0, '0},
    '{8'h35,    1'b0, '0},
    '{CR_BYTE,  1'b1, '{8'h00, 1'b0, 1'b1, 6'd0, 8'h05, 8'h05, 1'b1, 1'b0, 1'b1}},
    '{STX_BYTE, 1'b0, '0},
    '{8'h00,    1'b0, '0},
    '{8'hFF,    1'b0, '0},
    '{ETX_BYTE, 1'b0, '0},
    '{8'h46,    1'b0, '0},
    '{8'h65,    1'b0, '0},
    '{8'h0a,    1'b0, '0},
    '{STX_BYTE, 1'b0, '0},
    '{8'h41,    1'b0, '0},
    '{ETX_BYTE, 1'b0, '0},
    '{8'h34,    1'b0, '0},
    '{STX_BYTE, 1'b0, '0},
    '{ETX_BYTE, 1'b0, '0},
    '{8'h7a,    1'b0, '0},
    '{8'h35,    1'b0, '0},
    '{8'h00,    1'b1, '{8'h00, 1'b0, 1'b1, 6'd0, 8'h05, 8'hF5, 1'b0, 1'b0, 1'b0}},
    '{STX_BYTE, 1'b0, '0},
    '{ETX_BYTE, 1'b0, '0},
    '{8'h30,    1'b0, '0},
    '{8'h78,    1'b0, '0},
    '{CR_BYTE,  1'b1, '{8'h00, 1'b0, 1'b1, 6'd0, 8'h05, 8'hFF, 1'b0, 1'b0, 1'b1}}
  };

  stx_etx_hex_checksum_deframer_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_byte   (payload_byte),
    .payload_valid  (payload_valid),
    .last           (last),
    .payload_length (payload_length),
    .computed_sum   (computed_sum),
    .received_sum   (received_sum),
    .sum_ok         (sum_ok),
    .overflowed     (overflowed),
    .terminator_ok  (terminator_ok)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Bit 4 set means the character is not a hex digit.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] n;
    n = 5'h10;
    if (c inside {[8'h30:8'h39]}) n = {1'b0, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) n = {1'b0, c[3:0] + 4'd9};
    return n;
  endfunction

  function automatic string word_text(input frame_word_t w);
    return $sformatf("byte %h valid %b last %b len %0d sum %h rx %h ok %b ovf %b cr %b",
                     w.data, w.data_valid, w.run_last, w.length, w.calc_sum, w.rx_sum,
                     w.sum_match, w.dropped, w.cr_seen);
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic typed, input frame_word_t want);
    logic [4:0]  nib;
    int unsigned runs;
    frame_word_t w;
    if (b == STX_BYTE) begin
      rx_phase = IN_PAYLOAD;
      wr_pos   = 0;
      ovf_seen = 1'b0;
      sum_acc  = STX_BYTE;
    end else begin
      case (rx_phase)
        IN_PAYLOAD: begin
          sum_acc = sum_acc + b;
          if (b == ETX_BYTE) begin
            kept_len = wr_pos;
            rx_phase = CK_HIGH;
          end else begin
            shadow_buf[wr_pos] = b;
            wr_pos++;
            if (wr_pos >= CAPACITY) begin
              kept_len = wr_pos;
              rx_phase = IN_DROP;
            end
          end
        end
        IN_DROP: begin
          sum_acc = sum_acc + b;
          if (b == ETX_BYTE) rx_phase = CK_HIGH;
          else ovf_seen = 1'b1;
        end
        CK_HIGH: begin
          nib      = nibble_of(b);
          ck_acc   = nib[4] ? 8'hF0 : {nib[3:0], 4'h0};
          rx_phase = CK_LOW;
        end
        CK_LOW: begin
          nib      = nibble_of(b);
          ck_acc   = nib[4] ? 8'hFF : {ck_acc[7:4], nib[3:0]};
          rx_phase = AWAIT_END;
        end
        AWAIT_END: begin
          rx_phase = AWAIT_STX;
          if (typed) begin
            expected_words.push_back(want);
          end else begin
            runs = (kept_len == 0) ? 1 : kept_len;
            for (int unsigned k = 0; k < runs; k++) begin
              w.data       = (kept_len != 0) ? shadow_buf[k] : 8'h00;
              w.data_valid = kept_len != 0;
              w.run_last   = k + 1 == runs;
              w.length     = LEN_W'(kept_len);
              w.calc_sum   = sum_acc;
              w.rx_sum     = ck_acc;
              w.sum_match  = sum_acc == ck_acc;
              w.dropped    = ovf_seen;
              w.cr_seen    = b == CR_BYTE;
              expected_words.push_back(w);
            end
          end
        end
        default: rx_phase = AWAIT_STX;
      endcase
    end
  endtask

  // Entered and left at a falling edge.
  task automatic put_byte(input logic [7:0] b, input logic typed = 1'b0,
                          input frame_word_t want = '0);
    while (!steady && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_byte(b, typed, want);
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == STX_BYTE);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  task automatic send_frame(input int unsigned len);
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [7:0]  hi_c;
    logic [7:0]  lo_c;
    int unsigned pick;
    sum = STX_BYTE;
    put_byte(STX_BYTE);
    for (int unsigned i = 0; i < len; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == STX_BYTE || b == ETX_BYTE);
      sum = sum + b;
      put_byte(b);
    end
    sum = sum + ETX_BYTE;
    put_byte(ETX_BYTE);
    pick = $urandom_range(0, 9);
    if (pick == 7) sum = 8'($urandom_range(0, 255));
    hi_c = hex_char(sum[7:4]);
    lo_c = hex_char(sum[3:0]);
    if (pick == 8) hi_c = junk_byte();
    if (pick == 9) lo_c = junk_byte();
    put_byte(hi_c);
    put_byte(lo_c);
    // Mostly a proper terminator; now and then a restart or a stray byte.
    pick = $urandom_range(0, 19);
    put_byte(pick < 17 ? CR_BYTE : (pick == 17 ? STX_BYTE : junk_byte()));
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off so that the input backs up.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_taken >= 8) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  always @(posedge clk) begin : take_words
    frame_word_t got;
    frame_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{payload_byte, payload_valid, last, payload_length, computed_sum,
              received_sum, sum_ok, overflowed, terminator_ok};
      words_taken++;
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected word: %s", word_text(got));
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("word %0d mismatch", words_taken);
            $display("  expected %s", word_text(want));
            $display("  actual   %s", word_text(got));
          end
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned frames;
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    steady      = 1'b0;
    error_count = 0;
    words_taken = 0;
    cycle_count = 0;
    sent_count  = 0;
    frames      = 0;
    rx_phase    = AWAIT_STX;
    wr_pos      = 0;
    kept_len    = 0;
    sum_acc     = 8'h00;
    ck_acc      = 8'h00;
    ovf_seen    = 1'b0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      put_byte(directed_rows[i].code, directed_rows[i].typed, directed_rows[i].want);

    // A frame that exactly fills the buffer, then one that overflows it.
    send_frame(CAPACITY);
    send_frame(CAPACITY + 2);

    while (sent_count < ITEMS) begin
      steady = frames >= 4 && frames < 9;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        put_byte(STX_BYTE);
        repeat ($urandom_range(0, 4)) begin
          put_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        send_frame($urandom_range(0, 6));
      end
      frames++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
